### rtl/core/allocation_size_class_usage_monitor_assert.svh
// Assertion macros used by the allocation size-class usage monitor RTL.
`ifndef ALLOCATION_SIZE_CLASS_USAGE_MONITOR_ASSERT_SVH
`define ALLOCATION_SIZE_CLASS_USAGE_MONITOR_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define ASCUM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante.
`define ASCUM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/ascum_pkg.sv
// Shared types and codes of the allocation size-class usage monitor.
package ascum_pkg;

	// Event kinds; any other code acts as a query
	localparam logic [1:0] KIND_ALLOC = 2'd0;
	localparam logic [1:0] KIND_FREE  = 2'd1;
	localparam logic [1:0] KIND_QUERY = 2'd2;

	localparam int unsigned BYTES_W = 32;
	localparam int unsigned OUT_CLS_W = 4;
	localparam int unsigned OUT_CNT_W = 16;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_UPDATE
	} ctl_state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;
		logic commit;
	} dp_cmd_t;

endpackage

### rtl/core/ascum_evt_if.sv
// Event channel: valid/ready handshake carrying kind and byte size.
interface ascum_evt_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [31:0] size_bytes;

	modport source (output valid, kind, size_bytes, input ready);
	modport sink (input valid, kind, size_bytes, output ready);
endinterface

### rtl/core/ascum_rpt_if.sv
// Report channel: valid/ready handshake carrying the usage figures of one event.
interface ascum_rpt_if;
	logic        valid;
	logic        ready;
	logic [31:0] total_in_use;
	logic [31:0] total_peak;
	logic [3:0]  class_index;
	logic [15:0] class_in_use;
	logic [15:0] class_peak;
	logic        total_underflow;
	logic        class_underflow;

	modport source (output valid, total_in_use, total_peak, class_index, class_in_use,
		class_peak, total_underflow, class_underflow, input ready);
	modport sink (input valid, total_in_use, total_peak, class_index, class_in_use,
		class_peak, total_underflow, class_underflow, output ready);
endinterface

### rtl/core/ascum_dpath.sv
// Datapath: class encoder, byte totals, class counter memory and report register.
module ascum_dpath import ascum_pkg::*; #(
	parameter int unsigned NUM_CLASSES = 16,
	parameter int unsigned COUNT_BITS  = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dp_cmd_t              cmd,
	input  logic [1:0]           kind,
	input  logic [BYTES_W-1:0]   size_bytes,
	output logic [BYTES_W-1:0]   total_in_use,
	output logic [BYTES_W-1:0]   total_peak,
	output logic [OUT_CLS_W-1:0] class_index,
	output logic [OUT_CNT_W-1:0] class_in_use,
	output logic [OUT_CNT_W-1:0] class_peak,
	output logic                 total_underflow,
	output logic                 class_underflow
);

	localparam int unsigned CLS_W = $clog2(NUM_CLASSES);
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	logic [1:0]              kind_q;
	logic [BYTES_W-1:0]      size_q;
	logic [CLS_W-1:0]        cls_d;
	logic [CLS_W-1:0]        cls_q;

	logic [BYTES_W-1:0]      bytes_q;
	logic [BYTES_W-1:0]      bpeak_q;

	// Each word holds {peak, count} of one class
	logic [2*COUNT_BITS-1:0] mem [NUM_CLASSES];
	logic [NUM_CLASSES-1:0]  vld_q;
	logic [2*COUNT_BITS-1:0] rd_q;
	logic                    rd_vld_q;

	logic [COUNT_BITS-1:0]   cur_cnt;
	logic [COUNT_BITS-1:0]   cur_cpeak;
	logic [BYTES_W:0]        sum;
	logic [BYTES_W-1:0]      bytes_d;
	logic [BYTES_W-1:0]      bpeak_d;
	logic [COUNT_BITS-1:0]   cnt_d;
	logic [COUNT_BITS-1:0]   cpeak_d;
	logic                    tuf_d;
	logic                    cuf_d;

	// Pick the smallest class whose power of two covers the size; larger sizes take the top class
	always_comb begin
		cls_d = CLS_W'(NUM_CLASSES - 1);
		for (int i = int'(NUM_CLASSES) - 1; i >= 0; i--) begin
			if ({1'b0, size_bytes} <= (33'd1 << i)) begin
				cls_d = CLS_W'(i);
			end
		end
	end

	// Hold the event word for the read-modify-write
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= kind;
			size_q <= size_bytes;
			cls_q  <= cls_d;
		end
	end

	// Class counter memory: registered read, write on commit
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			mem[cls_q] <= {cpeak_d, cnt_d};
		end
		rd_q <= mem[cls_q];
	end

	// Entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				vld_q[cls_q] <= 1'b1;
			end
			rd_vld_q <= vld_q[cls_q];
		end
	end

	assign cur_cnt   = rd_vld_q ? rd_q[COUNT_BITS-1:0] : '0;
	assign cur_cpeak = rd_vld_q ? rd_q[2*COUNT_BITS-1:COUNT_BITS] : '0;
	assign sum       = {1'b0, bytes_q} + {1'b0, size_q};

	// Apply the event to the totals and the class counters
	always_comb begin
		bytes_d = bytes_q;
		bpeak_d = bpeak_q;
		cnt_d   = cur_cnt;
		cpeak_d = cur_cpeak;
		tuf_d   = 1'b0;
		cuf_d   = 1'b0;
		case (kind_q)
			KIND_ALLOC: begin
				bytes_d = sum[BYTES_W] ? '1 : sum[BYTES_W-1:0];
				if (bytes_d > bpeak_q) begin
					bpeak_d = bytes_d;
				end
				if (cur_cnt != CNT_MAX) begin
					cnt_d = cur_cnt + 1'b1;
				end
				if (cnt_d > cur_cpeak) begin
					cpeak_d = cnt_d;
				end
			end
			KIND_FREE: begin
				if (bytes_q < size_q) begin
					bytes_d = '0;
					tuf_d   = 1'b1;
				end else begin
					bytes_d = bytes_q - size_q;
				end
				if (cur_cnt == '0) begin
					cuf_d = 1'b1;
				end else begin
					cnt_d = cur_cnt - 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Update the byte totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_q <= '0;
			bpeak_q <= '0;
		end else if (cmd.commit) begin
			bytes_q <= bytes_d;
			bpeak_q <= bpeak_d;
		end
	end

	// Load the report word
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			total_in_use    <= bytes_d;
			total_peak      <= bpeak_d;
			class_index     <= OUT_CLS_W'(cls_q);
			class_in_use    <= OUT_CNT_W'(cnt_d);
			class_peak      <= OUT_CNT_W'(cpeak_d);
			total_underflow <= tuf_d;
			class_underflow <= cuf_d;
		end
	end

endmodule

### rtl/core/ascum_ctrl.sv
// Controller: sequences capture, counter lookup and commit, and owns report valid.
`include "allocation_size_class_usage_monitor_assert.svh"
module ascum_ctrl import ascum_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output dp_cmd_t cmd
);

	ctl_state_t state_q;
	ctl_state_t state_d;
	logic       out_valid_q;

	// Advance the state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.commit  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
				if (in_valid) begin
					state_d = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (!out_valid_q || out_ready) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Hold the report word until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	`ASCUM_ASSERT_IMP(a_commit_in_update, cmd.commit, state_q == ST_UPDATE, "commit outside update")
	`ASCUM_ASSERT_NXT(a_commit_sets_valid, cmd.commit, out_valid_q, "report lost after commit")
	`ASCUM_ASSERT_NXT(a_capture_to_lookup, cmd.capture, state_q == ST_LOOKUP, "capture did not start lookup")
	`ASCUM_ASSERT_IMP(a_no_overwrite, cmd.commit && out_valid_q, out_ready, "pending report overwritten")

endmodule

### rtl/core/allocation_size_class_usage_monitor.sv
// Top level of the allocation size-class usage monitor.
// Each event word (allocate, free or query with a byte size) is handled in order: it is
// captured and its power-of-two class encoded, then that class's count and peak are read
// from the counter memory through a registered read, and last the totals are updated, the
// class entry is written back and the report register is loaded. The read-modify-write of
// the counter memory sets these steps. A new event is taken as soon as the previous one is
// written back, even while its report still waits to be taken; a write-back waits only if
// the report register is still full. Counters saturate on overflow, frees clamp at zero and
// flag underflow. Valid bits clear the class memory at reset, so no clearing pass is needed.
module allocation_size_class_usage_monitor import ascum_pkg::*; #(
	parameter int unsigned NUM_CLASSES = 16,
	parameter int unsigned COUNT_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	ascum_evt_if.sink   evt,
	ascum_rpt_if.source rpt
);

	dp_cmd_t cmd;

	ascum_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (evt.valid),
		.in_ready  (evt.ready),
		.out_valid (rpt.valid),
		.out_ready (rpt.ready),
		.cmd       (cmd)
	);

	ascum_dpath #(
		.NUM_CLASSES (NUM_CLASSES),
		.COUNT_BITS  (COUNT_BITS)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.kind            (evt.kind),
		.size_bytes      (evt.size_bytes),
		.total_in_use    (rpt.total_in_use),
		.total_peak      (rpt.total_peak),
		.class_index     (rpt.class_index),
		.class_in_use    (rpt.class_in_use),
		.class_peak      (rpt.class_peak),
		.total_underflow (rpt.total_underflow),
		.class_underflow (rpt.class_underflow)
	);

endmodule
